@@ hdl/sbus_pkg.sv @@
// Shared types, widths and constants for the S.BUS channel decoder.
`timescale 1ns / 1ps

package sbus_pkg;

    // Frame layout
    localparam int NUM_CHANNELS  = 16;
    localparam int CHANNEL_BITS  = 11;
    localparam logic [7:0] SYNC_BYTE = 8'h0F;

    // Field widths
    localparam int BYTE_W     = 8;
    localparam int CNT_W      = 4;
    localparam int RAW_W      = 11;
    localparam int SCALED_W   = 13;
    localparam int GAIN_W     = 10;
    localparam int OFFSET_W   = 12;
    localparam int SCALED_MAX = (1 << SCALED_W) - 1;

    // Bit packer: a partial channel plus one new byte
    localparam int ACC_W  = CHANNEL_BITS + 7;
    localparam int HELD_W = $clog2(CHANNEL_BITS + 8);

    // floor(x / 1000) as (x * RECIP_M) >> RECIP_SHIFT, exact for x < 2**PROD_W
    localparam int PROD_W      = CHANNEL_BITS + GAIN_W;
    localparam int RECIP_SHIFT = PROD_W + 10;
    localparam int RECIP_W     = RECIP_SHIFT - 9;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd999) / 64'd1000);
    localparam int Q_W   = PROD_W + RECIP_W - RECIP_SHIFT;
    localparam int SUM_W = ((Q_W > OFFSET_W) ? Q_W : OFFSET_W) + 1;

    // Queue between the front and back parts
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

    // Ports
    localparam int OUT_TDATA_W = 32;
    localparam int ADDR_W      = 4;
    localparam int APB_DATA_W  = 32;

    typedef enum logic [1:0] {
        REG_DECODE_ENABLE = 2'd0,
        REG_GAIN_MILLI    = 2'd1,
        REG_VALUE_OFFSET  = 2'd2
    } t_reg_index;

    typedef struct packed {
        logic [CNT_W-1:0]        index;
        logic [CHANNEL_BITS-1:0] raw;
        logic                    last;
    } t_chan_item;

    typedef struct packed {
        logic [CNT_W-1:0]    index;
        logic [RAW_W-1:0]    raw;
        logic [SCALED_W-1:0] scaled;
        logic                last;
    } t_result;

endpackage

@@ hdl/sbus_front.sv @@
// Front part: frame tracking and bit packing of received bytes into channels.
`timescale 1ns / 1ps

module sbus_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_enable,
    input  logic                          i_accept,
    input  logic [sbus_pkg::BYTE_W-1:0]   i_rx_byte,
    input  logic                          i_frame_start,
    output logic                          o_push,
    output sbus_pkg::t_chan_item          o_item
);
    import sbus_pkg::*;

    logic                r_in_frame, n_in_frame;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [HELD_W-1:0]   r_held, n_held;
    logic [CNT_W-1:0]    r_cnt, n_cnt;

    logic [ACC_W-1:0]    acc_sum;
    logic [HELD_W-1:0]   held_sum;
    logic                chan_done;
    logic                last_chan;

    assign acc_sum   = r_acc | (ACC_W'(i_rx_byte) << r_held);
    assign held_sum  = r_held + HELD_W'(BYTE_W);
    assign chan_done = held_sum >= HELD_W'(CHANNEL_BITS);
    assign last_chan = r_cnt == CNT_W'(NUM_CHANNELS - 1);

    always_comb begin
        n_in_frame = r_in_frame;
        n_acc      = r_acc;
        n_held     = r_held;
        n_cnt      = r_cnt;
        o_push     = 1'b0;
        if (i_accept) begin
            if (!i_enable) begin
                n_in_frame = 1'b0;
            end else if (i_frame_start) begin
                n_in_frame = (i_rx_byte == SYNC_BYTE);
                n_acc      = '0;
                n_held     = '0;
                n_cnt      = '0;
            end else if (r_in_frame) begin
                if (chan_done) begin
                    o_push = 1'b1;
                    n_acc  = acc_sum >> CHANNEL_BITS;
                    n_held = held_sum - HELD_W'(CHANNEL_BITS);
                    if (last_chan) begin
                        n_in_frame = 1'b0;
                        n_cnt      = '0;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end else begin
                    n_acc  = acc_sum;
                    n_held = held_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_acc      <= '0;
            r_held     <= '0;
            r_cnt      <= '0;
        end else begin
            r_in_frame <= n_in_frame;
            r_acc      <= n_acc;
            r_held     <= n_held;
            r_cnt      <= n_cnt;
        end
    end

    assign o_item.index = r_cnt;
    assign o_item.raw   = acc_sum[CHANNEL_BITS-1:0];
    assign o_item.last  = last_chan;

endmodule

@@ hdl/sbus_fifo.sv @@
// Short queue of decoded channels between the front and back parts.
`timescale 1ns / 1ps

module sbus_fifo (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  sbus_pkg::t_chan_item  i_item,
    output logic                  o_full,
    input  logic                  i_pop,
    output logic                  o_valid,
    output sbus_pkg::t_chan_item  o_item
);
    import sbus_pkg::*;

    t_chan_item          r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]    r_rd_ptr, n_rd_ptr;
    logic [FILL_W-1:0]   r_fill, n_fill;
    logic                do_push;
    logic                do_pop;

    assign o_full  = r_fill == FILL_W'(FIFO_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_item  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_fill   = r_fill;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_fill = r_fill + FILL_W'(1);
        end else if (do_pop && !do_push) begin
            n_fill = r_fill - FILL_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

@@ hdl/sbus_back.sv @@
// Back part: three-stage scaling pipeline ending in the output register.
`timescale 1ns / 1ps

module sbus_back (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic [sbus_pkg::GAIN_W-1:0]     i_gain,
    input  logic [sbus_pkg::OFFSET_W-1:0]   i_offset,
    input  logic                            i_item_valid,
    input  sbus_pkg::t_chan_item            i_item,
    output logic                            o_pop,
    output logic                            o_valid,
    input  logic                            i_ready,
    output sbus_pkg::t_result               o_result
);
    import sbus_pkg::*;

    localparam int FULL_W = PROD_W + RECIP_W;

    logic                r_v1, r_v2, r_v3;
    t_chan_item          r_item1, r_item2;
    logic [PROD_W-1:0]   r_prod1;
    logic [Q_W-1:0]      r_q2;
    t_result             r_res;

    logic                en1, en2, en3;
    logic [FULL_W-1:0]   recip_prod;
    logic [SUM_W-1:0]    sum;
    logic [SCALED_W-1:0] scaled;

    // A stage loads when it is empty or its content moves on.
    assign en3   = !r_v3 || i_ready;
    assign en2   = !r_v2 || en3;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_item_valid && en1;

    assign recip_prod = FULL_W'(r_prod1) * FULL_W'(RECIP_M);
    assign sum        = SUM_W'(r_q2) + SUM_W'(i_offset);
    assign scaled     = (sum > SUM_W'(SCALED_MAX)) ? SCALED_W'(SCALED_MAX)
                                                   : SCALED_W'(sum);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_item_valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_item1 <= i_item;
            r_prod1 <= PROD_W'(i_item.raw) * PROD_W'(i_gain);
        end
        if (en2) begin
            r_item2 <= r_item1;
            r_q2    <= recip_prod[FULL_W-1 -: Q_W];
        end
        if (en3) begin
            r_res.index  <= r_item2.index;
            r_res.raw    <= RAW_W'(r_item2.raw);
            r_res.scaled <= scaled;
            r_res.last   <= r_item2.last;
        end
    end

    assign o_valid  = r_v3;
    assign o_result = r_res;

endmodule

@@ hdl/sbus_channel_decoder.sv @@
// Top level of the S.BUS channel decoder: register port, front, queue and back.
`timescale 1ns / 1ps

// Received bytes enter on the slave stream, one transaction per byte, with
// tuser marking the first byte of a frame. While decode_enable is set, a
// frame whose marked first byte is 0x0F is decoded: the following payload
// bytes are packed LSB first and every 11 completed bits leave as one channel
// transaction on the master stream, carrying the channel index, the raw value
// and floor(raw * gain_milli / 1000) + value_offset, with tlast on channel 15.
// Bytes after channel 15, unmarked bytes outside a frame and everything
// while decoding is disabled produce nothing. The block takes one byte per
// clock while the queue has room and delivers one channel per clock while
// m_axis_tready is high; a completed channel passes through the queue and
// then the three-stage scaling pipeline (gain multiply, reciprocal multiply
// for the division by 1000, offset add in the output register). A four-entry
// queue separates byte intake from scaling, so s_axis_tready falls only when
// that queue is full, which takes a stalled master side.
// Registers (32-bit APB, pready always high): 0x0 decode_enable (reset 0),
// 0x4 gain_milli (reset 753), 0x8 value_offset (reset 757); write them only
// while no channel is in flight.

module sbus_channel_decoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,

    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [sbus_pkg::ADDR_W-1:0]          paddr,
    input  logic [sbus_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [sbus_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                 pready,

    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [sbus_pkg::BYTE_W-1:0]          s_axis_tdata,  // [7:0] rx_byte
    input  logic                                 s_axis_tuser,  // [0] frame_start

    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // [3:0] channel_index, [14:4] raw_value, [27:15] scaled_value, [31:28] zero
    output logic [sbus_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                 m_axis_tlast   // last_channel
);
    import sbus_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - CNT_W - RAW_W - SCALED_W;

    logic                 r_decode_enable;
    logic [GAIN_W-1:0]    r_gain_milli;
    logic [OFFSET_W-1:0]  r_value_offset;

    logic                 cfg_write;
    t_reg_index           reg_sel;
    logic                 in_accept;
    logic                 fifo_full;
    logic                 front_push;
    t_chan_item           front_item;
    logic                 fifo_valid;
    t_chan_item           fifo_item;
    logic                 back_pop;
    t_result              result;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = t_reg_index'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_enable <= 1'b0;
            r_gain_milli    <= GAIN_W'(753);
            r_value_offset  <= OFFSET_W'(757);
        end else if (cfg_write) begin
            unique case (reg_sel)
                REG_DECODE_ENABLE: r_decode_enable <= pwdata[0];
                REG_GAIN_MILLI:    r_gain_milli    <= pwdata[GAIN_W-1:0];
                REG_VALUE_OFFSET:  r_value_offset  <= pwdata[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_DECODE_ENABLE: prdata = APB_DATA_W'(r_decode_enable);
            REG_GAIN_MILLI:    prdata = APB_DATA_W'(r_gain_milli);
            REG_VALUE_OFFSET:  prdata = APB_DATA_W'(r_value_offset);
            default:           prdata = '0;
        endcase
    end

    // Byte intake: every byte may yield one channel, so intake waits only
    // when the queue has no free entry.
    assign s_axis_tready = !fifo_full;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    sbus_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_enable      (r_decode_enable),
        .i_accept      (in_accept),
        .i_rx_byte     (s_axis_tdata),
        .i_frame_start (s_axis_tuser),
        .o_push        (front_push),
        .o_item        (front_item)
    );

    sbus_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_item  (front_item),
        .o_full  (fifo_full),
        .i_pop   (back_pop),
        .o_valid (fifo_valid),
        .o_item  (fifo_item)
    );

    sbus_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gain       (r_gain_milli),
        .i_offset     (r_value_offset),
        .i_item_valid (fifo_valid),
        .i_item       (fifo_item),
        .o_pop        (back_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_result     (result)
    );

    assign m_axis_tdata = {PAD_W'(0), result.scaled, result.raw, result.index};
    assign m_axis_tlast = result.last;

endmodule
